// ===== hw/rtl/pcent_pkg.sv =====
`timescale 1ns / 1ps

package pcent_pkg;

   localparam int COORD_BITS = 16;
   localparam int PROD_W     = 2 * COORD_BITS;
   localparam int CROSS_W    = 2 * COORD_BITS + 1;
   localparam int CSUM_W     = COORD_BITS + 1;
   localparam int WPROD_W    = CSUM_W + CROSS_W;
   localparam int DET_W      = 41;
   localparam int SUM_W      = 58;
   localparam int DEN_W      = DET_W + 2;
   localparam int STATUS_W   = 2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DEGEN = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SAT   = 2'd2;

   typedef struct packed {
      logic load;
      logic close;
      logic acc;
      logic load_den;
      logic div_start;
      logic div_sel_y;
      logic save_x;
      logic save_y;
      logic push;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic det_zero;
      logic over;
      logic div_done;
   } stat_type;

endpackage

// ===== hw/rtl/pcent_req_if.sv =====
`timescale 1ns / 1ps

interface pcent_req_if import pcent_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] vertex_x;
   logic signed [COORD_BITS-1:0] vertex_y;
   logic                         last_vertex;

   modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                   input ready);
   modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                   output ready);
endinterface

// ===== hw/rtl/pcent_rsp_if.sv =====
`timescale 1ns / 1ps

interface pcent_rsp_if import pcent_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] centroid_x;
   logic signed [COORD_BITS-1:0] centroid_y;
   logic [STATUS_W-1:0]          status;

   modport source (output valid, output centroid_x, output centroid_y, output status,
                   input ready);
   modport sink   (input valid, input centroid_x, input centroid_y, input status,
                   output ready);
endinterface

// ===== hw/rtl/pcent_div.sv =====
`timescale 1ns / 1ps

module pcent_div import pcent_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [SUM_W-1:0]      dividend,
   input  logic signed [DEN_W-1:0]      divisor,
   output logic                         done,
   output logic signed [COORD_BITS-1:0] quotient,
   output logic                         sat
);

   localparam int CNT_W = $clog2(SUM_W);
   localparam logic [SUM_W-1:0] QPOS_MAX = SUM_W'((64'd1 << (COORD_BITS - 1)) - 64'd1);
   localparam logic [SUM_W-1:0] QNEG_MAX = SUM_W'(64'd1 << (COORD_BITS - 1));
   localparam logic signed [COORD_BITS-1:0] OUT_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] OUT_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic             neg_ff, neg_in;

   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_sub;
   logic             fits;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[SUM_W-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      fits    = (rem_sh >= {1'b0, den_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
         den_in  = divisor[DEN_W-1] ? DEN_W'(-divisor) : divisor;
         neg_in  = dividend[SUM_W-1] ^ divisor[DEN_W-1];
      end else if (busy_ff) begin
         rem_in = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // clamp to the coordinate range, truncation toward zero comes from the magnitudes
   always_comb begin
      sat      = 1'b0;
      quotient = quo_ff[COORD_BITS-1:0];
      if (neg_ff) begin
         if (quo_ff > QNEG_MAX) begin
            sat      = 1'b1;
            quotient = OUT_MIN;
         end else begin
            quotient = -quo_ff[COORD_BITS-1:0];
         end
      end else if (quo_ff > QPOS_MAX) begin
         sat      = 1'b1;
         quotient = OUT_MAX;
      end
   end

   assign done = done_ff;

endmodule

// ===== hw/rtl/pcent_dp.sv =====
`timescale 1ns / 1ps

module pcent_dp import pcent_pkg::*; #(
   parameter int MAX_VERTICES = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   output stat_type                     stat,
   input  logic signed [COORD_BITS-1:0] vertex_x,
   input  logic signed [COORD_BITS-1:0] vertex_y,
   input  logic                         last_vertex,
   output logic signed [COORD_BITS-1:0] centroid_x,
   output logic signed [COORD_BITS-1:0] centroid_y,
   output logic [STATUS_W-1:0]          status
);

   localparam int VCNT_W = $clog2(MAX_VERTICES + 2);

   logic signed [COORD_BITS-1:0] cur_x_ff, cur_y_ff, first_x_ff, first_y_ff;
   logic signed [COORD_BITS-1:0] prev_x_ff, prev_y_ff;
   logic                         last_ff, have_first_ff;
   logic [VCNT_W-1:0]            vcount_ff;
   logic [DET_W-1:0]             det_sum_ff;
   logic [SUM_W-1:0]             wx_sum_ff, wy_sum_ff;

   logic signed [COORD_BITS-1:0] a_x, a_y, b_x, b_y;
   logic signed [PROD_W-1:0]     p1_ff, p1_in, p2_ff, p2_in;
   logic signed [CSUM_W-1:0]     sx_ff, sx_in, sy_ff, sy_in;
   logic signed [CROSS_W-1:0]    t_ff, t_in;
   logic signed [WPROD_W-1:0]    wxp_ff, wxp_in, wyp_ff, wyp_in;
   logic signed [DEN_W-1:0]      den_ff, den_in;
   logic signed [DEN_W-1:0]      det_ext;

   logic signed [COORD_BITS-1:0] res_x_ff, res_y_ff;
   logic                         sat_x_ff, sat_y_ff;
   logic signed [COORD_BITS-1:0] out_x_ff, out_y_ff;
   logic [STATUS_W-1:0]          out_st_ff;

   logic                         over, det_zero;
   logic                         div_done, div_sat;
   logic signed [COORD_BITS-1:0] div_q;
   logic [STATUS_W-1:0]          st_in;

   // edge operands: prev to current, or current back to first
   always_comb begin
      a_x = cmd.close ? cur_x_ff   : prev_x_ff;
      a_y = cmd.close ? cur_y_ff   : prev_y_ff;
      b_x = cmd.close ? first_x_ff : cur_x_ff;
      b_y = cmd.close ? first_y_ff : cur_y_ff;
   end

   always_comb begin
      p1_in  = PROD_W'(a_x) * PROD_W'(b_y);
      p2_in  = PROD_W'(b_x) * PROD_W'(a_y);
      sx_in  = CSUM_W'(a_x) + CSUM_W'(b_x);
      sy_in  = CSUM_W'(a_y) + CSUM_W'(b_y);
      t_in   = CROSS_W'(p1_ff) - CROSS_W'(p2_ff);
      wxp_in = sx_ff * t_ff;
      wyp_in = sy_ff * t_ff;
      det_ext = {{(DEN_W-DET_W){det_sum_ff[DET_W-1]}}, det_sum_ff};
      den_in  = (det_ext <<< 1) + det_ext;
   end

   always_ff @(posedge clock) begin
      p1_ff  <= p1_in;
      p2_ff  <= p2_in;
      sx_ff  <= sx_in;
      sy_ff  <= sy_in;
      t_ff   <= t_in;
      wxp_ff <= wxp_in;
      wyp_ff <= wyp_in;
   end

   assign over     = vcount_ff > VCNT_W'(MAX_VERTICES);
   assign det_zero = det_sum_ff == '0;

   always_ff @(posedge clock) begin
      if (reset || cmd.push) begin
         first_x_ff    <= '0;
         first_y_ff    <= '0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         have_first_ff <= 1'b0;
         vcount_ff     <= '0;
         det_sum_ff    <= '0;
         wx_sum_ff     <= '0;
         wy_sum_ff     <= '0;
         last_ff       <= 1'b0;
      end else begin
         if (cmd.load) begin
            last_ff <= last_vertex;
            if (!over) begin
               vcount_ff <= vcount_ff + VCNT_W'(1);
            end
            if (!have_first_ff) begin
               first_x_ff    <= vertex_x;
               first_y_ff    <= vertex_y;
               have_first_ff <= 1'b1;
            end
         end
         if (cmd.acc) begin
            det_sum_ff <= det_sum_ff + {{(DET_W-CROSS_W){t_ff[CROSS_W-1]}}, t_ff};
            wx_sum_ff  <= wx_sum_ff + {{(SUM_W-WPROD_W){wxp_ff[WPROD_W-1]}}, wxp_ff};
            wy_sum_ff  <= wy_sum_ff + {{(SUM_W-WPROD_W){wyp_ff[WPROD_W-1]}}, wyp_ff};
            if (!cmd.close) begin
               prev_x_ff <= cur_x_ff;
               prev_y_ff <= cur_y_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_x_ff <= vertex_x;
         cur_y_ff <= vertex_y;
      end
      if (cmd.load_den) begin
         den_ff <= den_in;
      end
      if (cmd.save_x) begin
         res_x_ff <= div_q;
         sat_x_ff <= div_sat;
      end
      if (cmd.save_y) begin
         res_y_ff <= div_q;
         sat_y_ff <= div_sat;
      end
   end

   pcent_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (cmd.div_sel_y ? wy_sum_ff : wx_sum_ff),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_q),
      .sat      (div_sat)
   );

   always_comb begin
      if (over) begin
         st_in = STATUS_SAT;
      end else if (det_zero) begin
         st_in = STATUS_DEGEN;
      end else if (sat_x_ff || sat_y_ff) begin
         st_in = STATUS_SAT;
      end else begin
         st_in = STATUS_OK;
      end
   end

   // output register, loaded as the polygon state clears
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         out_x_ff  <= (over || det_zero) ? '0 : res_x_ff;
         out_y_ff  <= (over || det_zero) ? '0 : res_y_ff;
         out_st_ff <= st_in;
      end
   end

   assign stat.last     = last_ff;
   assign stat.det_zero = det_zero;
   assign stat.over     = over;
   assign stat.div_done = div_done;

   assign centroid_x = out_x_ff;
   assign centroid_y = out_y_ff;
   assign status     = out_st_ff;

endmodule

// ===== hw/rtl/pcent_ctrl.sv =====
`timescale 1ns / 1ps

module pcent_ctrl import pcent_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [10:0] {
      ST_IDLE      = 11'b000_0000_0001,
      ST_MUL       = 11'b000_0000_0010,
      ST_SUB       = 11'b000_0000_0100,
      ST_MUL2      = 11'b000_0000_1000,
      ST_ACC       = 11'b000_0001_0000,
      ST_CHECK     = 11'b000_0010_0000,
      ST_DIVX_GO   = 11'b000_0100_0000,
      ST_DIVX_WAIT = 11'b000_1000_0000,
      ST_DIVY_GO   = 11'b001_0000_0000,
      ST_DIVY_WAIT = 11'b010_0000_0000,
      ST_OUT       = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      close_ff, close_in;
   logic      valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      close_in = close_ff;
      cmd      = '0;
      cmd.close = close_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               close_in = 1'b0;
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_SUB;
         ST_SUB:  state_in = ST_MUL2;
         ST_MUL2: state_in = ST_ACC;
         ST_ACC: begin
            cmd.acc = 1'b1;
            if (stat.last && !close_ff) begin
               close_in = 1'b1;
               state_in = ST_MUL;
            end else if (stat.last) begin
               state_in = ST_CHECK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_CHECK: begin
            if (stat.over || stat.det_zero) begin
               state_in = ST_OUT;
            end else begin
               cmd.load_den = 1'b1;
               state_in     = ST_DIVX_GO;
            end
         end
         ST_DIVX_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIVX_WAIT;
         end
         ST_DIVX_WAIT: begin
            if (stat.div_done) begin
               cmd.save_x = 1'b1;
               state_in   = ST_DIVY_GO;
            end
         end
         ST_DIVY_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel_y = 1'b1;
            state_in      = ST_DIVY_WAIT;
         end
         ST_DIVY_WAIT: begin
            if (stat.div_done) begin
               cmd.save_y = 1'b1;
               state_in   = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!valid_ff || rsp_ready) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.push) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         close_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         close_ff <= close_in;
         valid_ff <= valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule

// ===== hw/rtl/polygon_centroid.sv =====
`timescale 1ns / 1ps

// channel    dir  fields                              item
// req_chan   in   vertex_x, vertex_y, last_vertex     one polygon vertex
// rsp_chan   out  centroid_x, centroid_y, status      one result per polygon
//
// a vertex is handled in steps: accept, then multiply, subtract, multiply, accumulate
// the last vertex adds the closing edge (the same steps after the accept) and a check state; a zero
// area or too many vertices goes straight out, otherwise two restoring divisions share
// the one divider, each a start state and a wait state before the quotient is saved
// synchronous reset clears the controller and the polygon accumulators
// the result sits in an output register; new vertices are taken while it waits,
// and the next result holds in the output state until the waiting item is taken

module polygon_centroid import pcent_pkg::*; #(
   parameter int MAX_VERTICES = 256
) (
   input  logic         clock,
   input  logic         reset,
   pcent_req_if.sink    req_chan,
   pcent_rsp_if.source  rsp_chan
);

   cmd_type  cmd;
   stat_type stat;

   pcent_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pcent_dp #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .vertex_x    (req_chan.vertex_x),
      .vertex_y    (req_chan.vertex_y),
      .last_vertex (req_chan.last_vertex),
      .centroid_x  (rsp_chan.centroid_x),
      .centroid_y  (rsp_chan.centroid_y),
      .status      (rsp_chan.status)
   );

endmodule

// ===== dv/polygon_centroid_tb.sv =====
`timescale 1ns / 1ps

module polygon_centroid_tb;
   import pcent_pkg::*;

   localparam int MAX_VERTS    = 256;
   localparam int DIR_ROWS     = 25;
   localparam int RAND_ITEMS   = 1950;
   localparam int CALM_ITEMS   = 150;
   localparam int WATCHDOG     = 5000;
   localparam int DRAIN_CYCLES = 300;

   typedef struct {
      logic signed [COORD_BITS-1:0] cx;
      logic signed [COORD_BITS-1:0] cy;
      logic [STATUS_W-1:0]          st;
   } centroid_type;

   typedef struct {
      int                  x;
      int                  y;
      bit                  last;
      bit                  typed;
      int                  want_x;
      int                  want_y;
      logic [STATUS_W-1:0] want_st;
   } dir_row_type;

   logic clock;
   logic reset;

   pcent_req_if req_bus ();
   pcent_rsp_if rsp_bus ();

   polygon_centroid #(.MAX_VERTICES(MAX_VERTS)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // shoelace predictor state
   logic signed [COORD_BITS-1:0] first_xs, first_ys, prev_xs, prev_ys;
   bit                           seen_first;
   logic [DET_W-1:0]             area2_acc;
   logic [SUM_W-1:0]             mom_x_acc, mom_y_acc;
   int                           vert_count;

   centroid_type pending_centroids [$];
   int           poly_x [$];
   int           poly_y [$];
   dir_row_type  dir_tab [DIR_ROWS];

   // typed expectation travelling with the current item
   bit                           want_typed;
   logic signed [COORD_BITS-1:0] want_cx, want_cy;
   logic [STATUS_W-1:0]          want_st;

   bit failed;
   bit calm;
   bit quiet_req;
   bit quiet_rsp;
   int stall_left;
   int items_sent;
   int idle_cycles;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic void clear_polygon();
      first_xs   = '0;
      first_ys   = '0;
      prev_xs    = '0;
      prev_ys    = '0;
      seen_first = 1'b0;
      area2_acc  = '0;
      mom_x_acc  = '0;
      mom_y_acc  = '0;
      vert_count = 0;
   endfunction

   function automatic void add_edge(longint ax, longint ay, longint bx, longint by);
      longint t, wx, wy;
      t  = ax * by - bx * ay;
      wx = (ax + bx) * t;
      wy = (ay + by) * t;
      area2_acc = area2_acc + t[DET_W-1:0];
      mom_x_acc = mom_x_acc + wx[SUM_W-1:0];
      mom_y_acc = mom_y_acc + wy[SUM_W-1:0];
   endfunction

   function automatic logic signed [COORD_BITS-1:0] clamp_coord(longint q, inout bit sat);
      longint hi, lo;
      hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
      lo = -hi - 1;
      if (q > hi) begin
         sat = 1'b1;
         return hi[COORD_BITS-1:0];
      end
      if (q < lo) begin
         sat = 1'b1;
         return lo[COORD_BITS-1:0];
      end
      return q[COORD_BITS-1:0];
   endfunction

   task automatic predict_vertex(input logic signed [COORD_BITS-1:0] x,
                                 input logic signed [COORD_BITS-1:0] y,
                                 input logic last, output bit got, output centroid_type res);
      longint d, mx, my;
      bit     sat;
      got    = 1'b0;
      sat    = 1'b0;
      res.cx = '0;
      res.cy = '0;
      res.st = STATUS_OK;
      if (vert_count <= MAX_VERTS) vert_count++;
      if (!seen_first) begin
         first_xs   = x;
         first_ys   = y;
         seen_first = 1'b1;
      end else begin
         add_edge(prev_xs, prev_ys, x, y);
      end
      prev_xs = x;
      prev_ys = y;
      if (last) begin
         add_edge(x, y, first_xs, first_ys);
         got = 1'b1;
         if (vert_count > MAX_VERTS) begin
            res.st = STATUS_SAT;
         end else begin
            d = $signed(area2_acc);
            if (d == 0) begin
               res.st = STATUS_DEGEN;
            end else begin
               mx     = $signed(mom_x_acc);
               my     = $signed(mom_y_acc);
               res.cx = clamp_coord(mx / (3 * d), sat);
               res.cy = clamp_coord(my / (3 * d), sat);
               res.st = sat ? STATUS_SAT : STATUS_OK;
            end
         end
         clear_polygon();
      end
   endtask

   function automatic int rand_coord();
      logic signed [COORD_BITS-1:0] r;
      r = COORD_BITS'($urandom);
      return r;
   endfunction

   function automatic int pick_centre(int half);
      return int'($urandom_range(0, 2 * (32767 - half))) - (32767 - half);
   endfunction

   function automatic void add_point(int x, int y);
      poly_x = {poly_x, x};
      poly_y = {poly_y, y};
   endfunction

   task automatic send_vertex(input int x, input int y, input bit last, input bit typed,
                              input int wx, input int wy, input logic [STATUS_W-1:0] wst);
      int gap;
      if (!calm && !quiet_req && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.vertex_x    <= x[COORD_BITS-1:0];
      req_bus.vertex_y    <= y[COORD_BITS-1:0];
      req_bus.last_vertex <= last;
      want_typed          <= typed;
      want_cx             <= wx[COORD_BITS-1:0];
      want_cy             <= wy[COORD_BITS-1:0];
      want_st             <= wst;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      calm = (items_sent >= DIR_ROWS + RAND_ITEMS - CALM_ITEMS);
      @(negedge clock);
   endtask

   // result side back-pressure
   always @(negedge clock) begin : rsp_pacing
      if (calm) begin
         rsp_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else if (!quiet_rsp && $urandom_range(0, 2) == 0) begin
         stall_left = $urandom_range(0, 4);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
      if ($urandom_range(0, 63) == 0) quiet_rsp = !quiet_rsp;
   end

   always @(posedge clock) begin : monitor
      bit           got, moved;
      centroid_type calc, want;
      if (!reset) begin
         moved = 1'b0;
         if (req_bus.valid && req_bus.ready) begin
            moved = 1'b1;
            predict_vertex(req_bus.vertex_x, req_bus.vertex_y, req_bus.last_vertex, got, calc);
            if (got) begin
               if (want_typed) begin
                  want.cx = want_cx;
                  want.cy = want_cy;
                  want.st = want_st;
                  pending_centroids = {pending_centroids, want};
               end else begin
                  pending_centroids = {pending_centroids, calc};
               end
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved = 1'b1;
            if (pending_centroids.size() == 0) begin
               $display("%0t unexpected centroid item: x %0d y %0d status %0d", $time,
                        rsp_bus.centroid_x, rsp_bus.centroid_y, rsp_bus.status);
               failed = 1'b1;
            end else begin
               want = pending_centroids.pop_front();
               if (rsp_bus.centroid_x !== want.cx) begin
                  $display("%0t centroid_x mismatch: expected %0d, actual %0d", $time,
                           want.cx, rsp_bus.centroid_x);
                  failed = 1'b1;
               end
               if (rsp_bus.centroid_y !== want.cy) begin
                  $display("%0t centroid_y mismatch: expected %0d, actual %0d", $time,
                           want.cy, rsp_bus.centroid_y);
                  failed = 1'b1;
               end
               if (rsp_bus.status !== want.st) begin
                  $display("%0t status mismatch: expected %0d, actual %0d", $time,
                           want.st, rsp_bus.status);
                  failed = 1'b1;
               end
            end
         end
         if (moved) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
               $display("%0t watchdog: no handshake for %0d cycles", $time, idle_cycles);
               $display("== FAIL ==");
               $finish;
            end
         end
      end
   end

   initial begin : stimulus
      int n, kind, s, h, cx, cy, dx, dy, px, py, poly_no;
      bit flip;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.vertex_x    = '0;
      req_bus.vertex_y    = '0;
      req_bus.last_vertex = 1'b0;
      rsp_bus.ready       = 1'b0;
      want_typed          = 1'b0;
      want_cx             = '0;
      want_cy             = '0;
      want_st             = STATUS_OK;
      failed              = 1'b0;
      calm                = 1'b0;
      quiet_req           = 1'b0;
      quiet_rsp           = 1'b0;
      stall_left          = 0;
      items_sent          = 0;
      idle_cycles         = 0;
      clear_polygon();

      dir_tab = '{
         // single vertex
         '{5, 7, 1'b1, 1'b1, 0, 0, STATUS_DEGEN},
         // two vertices at opposite extremes
         '{-32768, 32767, 1'b0, 1'b0, 0, 0, STATUS_OK},
         '{32767, -32768, 1'b1, 1'b1, 0, 0, STATUS_DEGEN},
         // collinear
         '{0, 0, 1'b0, 1'b0, 0, 0, STATUS_OK},
         '{1, 1, 1'b0, 1'b0, 0, 0, STATUS_OK},
         '{2, 2, 1'b1, 1'b1, 0, 0, STATUS_DEGEN},
         // anticlockwise square
         '{0, 0, 1'b0, 1'b0, 0, 0, STATUS_OK},
         '{6, 0, 1'b0, 1'b0, 0, 0, STATUS_OK},
         '{6, 6, 1'b0, 1'b0, 0, 0, STATUS_OK},
         '{0, 6, 1'b1, 1'b1, 3, 3, STATUS_OK},
         // clockwise square, negative area
         '{0, 0, 1'b0, 1'b0, 0, 0, STATUS_OK},
         '{0, -6, 1'b0, 1'b0, 0, 0, STATUS_OK},
         '{-6, -6, 1'b0, 1'b0, 0, 0, STATUS_OK},
         '{-6, 0, 1'b1, 1'b1, -3, -3, STATUS_OK},
         // full-range square
         '{-32768, -32768, 1'b0, 1'b0, 0, 0, STATUS_OK},
         '{32767, -32768, 1'b0, 1'b0, 0, 0, STATUS_OK},
         '{32767, 32767, 1'b0, 1'b0, 0, 0, STATUS_OK},
         '{-32768, 32767, 1'b1, 1'b0, 0, 0, STATUS_OK},
         // full-range triangle
         '{-32768, -32768, 1'b0, 1'b0, 0, 0, STATUS_OK},
         '{32767, -32768, 1'b0, 1'b0, 0, 0, STATUS_OK},
         '{-32768, 32767, 1'b1, 1'b0, 0, 0, STATUS_OK},
         // lopsided bow-tie, near-zero area with large moments
         '{-30000, -1000, 1'b0, 1'b0, 0, 0, STATUS_OK},
         '{30000, 1001, 1'b0, 1'b0, 0, 0, STATUS_OK},
         '{30000, -1000, 1'b0, 1'b0, 0, 0, STATUS_OK},
         '{-30000, 1000, 1'b1, 1'b0, 0, 0, STATUS_OK}
      };

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         send_vertex(dir_tab[i].x, dir_tab[i].y, dir_tab[i].last, dir_tab[i].typed,
                     dir_tab[i].want_x, dir_tab[i].want_y, dir_tab[i].want_st);
      end

      poly_no = 0;
      while (items_sent < DIR_ROWS + RAND_ITEMS) begin
         poly_x.delete();
         poly_y.delete();
         if ($urandom_range(0, 7) == 0) quiet_req = !quiet_req;
         if (poly_no == 30 || poly_no == 90 || poly_no == 150) begin
            // vertex limit: exactly at it, one over, a few over
            n = (poly_no == 30) ? MAX_VERTS : (poly_no == 90) ? MAX_VERTS + 1 : MAX_VERTS + 4;
            for (int k = 0; k < n; k++) begin
               add_point(int'($urandom_range(0, 400)) - 200, int'($urandom_range(0, 400)) - 200);
            end
         end else begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
               s  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16000) : $urandom_range(1, 300);
               h  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16000) : $urandom_range(1, 300);
               cx = pick_centre(s);
               cy = pick_centre(h);
               flip = 1'($urandom_range(0, 1));
               if ($urandom_range(0, 1)) begin
                  add_point(cx - s, cy - h);
                  if (!flip) begin
                     add_point(cx + s, cy - h);
                     add_point(cx + s, cy + h);
                     add_point(cx - s, cy + h);
                  end else begin
                     add_point(cx - s, cy + h);
                     add_point(cx + s, cy + h);
                     add_point(cx + s, cy - h);
                  end
               end else begin
                  for (int k = 0; k < 3; k++) begin
                     add_point(cx + int'($urandom_range(0, 2 * s)) - s,
                               cy + int'($urandom_range(0, 2 * h)) - h);
                  end
               end
            end else if (kind < 70) begin
               n = $urandom_range(3, 8);
               for (int k = 0; k < n; k++) add_point(rand_coord(), rand_coord());
            end else if (kind < 85) begin
               n = $urandom_range(3, 12);
               for (int k = 0; k < n; k++) begin
                  add_point(int'($urandom_range(0, 200)) - 100, int'($urandom_range(0, 200)) - 100);
               end
            end else if (kind < 90) begin
               n = $urandom_range(1, 2);
               for (int k = 0; k < n; k++) add_point(rand_coord(), rand_coord());
            end else if (kind < 95) begin
               // points on one line
               n  = $urandom_range(3, 5);
               px = int'($urandom_range(0, 2000)) - 1000;
               py = int'($urandom_range(0, 2000)) - 1000;
               dx = int'($urandom_range(0, 100)) - 50;
               dy = int'($urandom_range(0, 100)) - 50;
               for (int k = 0; k < n; k++) add_point(px + k * dx, py + k * dy);
            end else begin
               // one point repeated
               n  = $urandom_range(2, 4);
               px = rand_coord();
               py = rand_coord();
               for (int k = 0; k < n; k++) add_point(px, py);
            end
         end
         for (int k = 0; k < poly_x.size(); k++) begin
            send_vertex(poly_x[k], poly_y[k], k == poly_x.size() - 1, 1'b0, 0, 0, STATUS_OK);
         end
         poly_no++;
      end
      req_bus.valid <= 1'b0;

      while (pending_centroids.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== polygon_centroid.f =====
hw/rtl/pcent_pkg.sv
hw/rtl/pcent_req_if.sv
hw/rtl/pcent_rsp_if.sv
hw/rtl/pcent_div.sv
hw/rtl/pcent_dp.sv
hw/rtl/pcent_ctrl.sv
hw/rtl/polygon_centroid.sv
dv/polygon_centroid_tb.sv
